### rtl/ptma_pkg.sv
// Shared types, field widths and calendar helpers for the packed timestamp minute adder.
package ptma_pkg;

  // Field widths of the packed stamp
  localparam int YEAR_W   = 6;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int OFFSET_W = 16;
  localparam int STAMP_IN_W  = 32;
  localparam int STAMP_OUT_W = 31;
  localparam int PAD_W       = 5;

  // Quotient by 60 of a 16-bit magnitude: q = (mag * RECIP_60) >> RECIP_SHIFT
  localparam int PROD_W      = 31;
  localparam int QUOT_W      = 10;
  localparam int RECIP_SHIFT = 21;
  localparam logic [16:0] RECIP_60 = 17'd34953;

  localparam logic [QUOT_W-1:0] MAX_HOURS = 10'd12;
  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] APRIL    = 4'd4;
  localparam logic [MONTH_W-1:0] JUNE     = 4'd6;
  localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
  localparam logic [MONTH_W-1:0] NOVEMBER = 4'd11;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  yr;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   dy;
    logic [HOUR_W-1:0]  hr;
    logic [MIN_W-1:0]   mn;
  } stamp_t;

  // Day carry or borrow requested by the hour/minute logic
  typedef struct packed {
    logic fwd;
    logic bwd;
  } day_step_t;

  // Leap years: the year offset only spans 2000..2063, so the century rule
  // only touches offset 0 (2000), which is a leap year. Divisible by 4 is enough.
  function automatic logic [DAY_W-1:0] days_in(input logic [YEAR_W-1:0] yr,
                                                input logic [MONTH_W-1:0] mo);
    logic leap;
    logic [DAY_W-1:0] len;
    leap = (yr[1:0] == 2'd0);
    case (mo)
      FEBRUARY:  len = leap ? 5'd29 : 5'd28;
      APRIL:     len = 5'd30;
      JUNE:      len = 5'd30;
      SEPTEMBER: len = 5'd30;
      NOVEMBER:  len = 5'd30;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic stamp_t unpack_stamp(input logic [STAMP_IN_W-1:0] s);
    stamp_t f;
    f.yr = s[30:25];
    f.mo = s[24:21];
    f.dy = s[20:16];
    f.hr = s[15:11];
    f.mn = s[10:5];
    return f;
  endfunction

  function automatic logic [STAMP_OUT_W-1:0] pack_stamp(input stamp_t f);
    return {f.yr, f.mo, f.dy, f.hr, f.mn, {PAD_W{1'b0}}};
  endfunction

endpackage

### rtl/ptma_divmod60.sv
// Splits the signed minute offset into an hour amount and leftover minutes.
module ptma_divmod60 (
  input  logic [ptma_pkg::OFFSET_W-1:0] offset,
  output logic                          neg,
  output logic                          nonzero,
  output logic [3:0]                    hour_amt,
  output logic [ptma_pkg::MIN_W-1:0]    rem
);

  logic [ptma_pkg::OFFSET_W-1:0] mag;
  logic [ptma_pkg::PROD_W-1:0]   prod;
  logic [ptma_pkg::QUOT_W-1:0]   quot;
  logic [ptma_pkg::OFFSET_W-1:0] quot_x60;
  logic [ptma_pkg::OFFSET_W-1:0] rem_full;

  // Magnitude; -32768 maps to 16'h8000, still correct as unsigned
  assign neg     = offset[ptma_pkg::OFFSET_W-1];
  assign nonzero = (offset != '0);
  assign mag     = neg ? (~offset + 16'd1) : offset;

  // Reciprocal multiply, exact for every magnitude up to 2^15
  assign prod = {15'd0, mag} * {14'd0, ptma_pkg::RECIP_60};
  assign quot = prod[ptma_pkg::RECIP_SHIFT +: ptma_pkg::QUOT_W];

  // Remainder = mag - 60*q, 60*q as shift-subtract (64q - 4q)
  assign quot_x60 = {quot, 6'd0} - {4'd0, quot, 2'd0};
  assign rem_full = mag - quot_x60;
  assign rem      = rem_full[ptma_pkg::MIN_W-1:0];

  // Hour part applied only when its magnitude is at most twelve
  assign hour_amt = (quot <= ptma_pkg::MAX_HOURS) ? quot[3:0] : 4'd0;

endmodule

### rtl/ptma_time_step.sv
// Hour and minute arithmetic; reports a day carry or borrow.
module ptma_time_step (
  input  logic [ptma_pkg::HOUR_W-1:0] hr,
  input  logic [ptma_pkg::MIN_W-1:0]  mn,
  input  logic                        neg,
  input  logic                        nonzero,
  input  logic [3:0]                  hour_amt,
  input  logic [ptma_pkg::MIN_W-1:0]  rem,
  output logic [ptma_pkg::HOUR_W-1:0] hr_new,
  output logic [ptma_pkg::MIN_W-1:0]  mn_new,
  output ptma_pkg::day_step_t         day_step
);

  logic       pos;
  logic [6:0] msum;
  logic [6:0] mdiff;
  logic       min_carry;
  logic       min_borrow;
  logic [5:0] hsum;
  logic [6:0] hdiff;
  logic       hr_carry;
  logic       hr_borrow;

  assign pos = nonzero && !neg;

  // Minutes: add with carry past 59, or subtract with borrow below zero
  assign msum       = {1'b0, mn} + {1'b0, rem};
  assign mdiff      = {1'b0, mn} - {1'b0, rem};
  assign min_carry  = pos && (msum > 7'd59);
  assign min_borrow = neg && mdiff[6];

  // Hours: hour part and minute carry folded into one add/subtract.
  // Forward carry only fires when something was actually added, so an
  // out-of-range hour with nothing added is left alone.
  assign hsum      = {1'b0, hr} + {2'd0, hour_amt} + {5'd0, min_carry};
  assign hr_carry  = pos && (hsum > 6'd23) && ((hour_amt != 4'd0) || min_carry);
  assign hdiff     = {2'd0, hr} - {3'd0, hour_amt} - {6'd0, min_borrow};
  assign hr_borrow = neg && hdiff[6];

  always_comb begin
    hr_new = hr;
    mn_new = mn;
    if (neg) begin
      mn_new = min_borrow ? 6'(mdiff + 7'd60) : mdiff[5:0];
      hr_new = hr_borrow ? 5'(hdiff + 7'd24) : hdiff[4:0];
    end else if (pos) begin
      mn_new = min_carry ? 6'(msum - 7'd60) : msum[5:0];
      hr_new = hr_carry ? 5'(hsum - 6'd24) : hsum[4:0];
    end
  end

  assign day_step.fwd = hr_carry;
  assign day_step.bwd = hr_borrow;

endmodule

### rtl/ptma_date_step.sv
// One-day step forward or backward through day, month and year.
module ptma_date_step (
  input  logic [ptma_pkg::YEAR_W-1:0]  yr,
  input  logic [ptma_pkg::MONTH_W-1:0] mo,
  input  logic [ptma_pkg::DAY_W-1:0]   dy,
  input  ptma_pkg::day_step_t          day_step,
  output logic [ptma_pkg::YEAR_W-1:0]  yr_new,
  output logic [ptma_pkg::MONTH_W-1:0] mo_new,
  output logic [ptma_pkg::DAY_W-1:0]   dy_new
);

  logic [5:0]                     dnext;
  logic                           fwd_over;
  logic [ptma_pkg::YEAR_W-1:0]    prev_yr;
  logic [ptma_pkg::MONTH_W-1:0]   prev_mo;

  // Forward: roll to the 1st when past the current month's length
  assign dnext    = {1'b0, dy} + 6'd1;
  assign fwd_over = dnext > {1'b0, ptma_pkg::days_in(yr, mo)};

  // Backward: previous month and its year, for the borrowed length
  assign prev_mo = (mo <= ptma_pkg::JANUARY) ? ptma_pkg::DECEMBER : (mo - 4'd1);
  assign prev_yr = (mo <= ptma_pkg::JANUARY) ? (yr - 6'd1) : yr;

  always_comb begin
    yr_new = yr;
    mo_new = mo;
    dy_new = dy;
    if (day_step.fwd) begin
      if (fwd_over) begin
        dy_new = 5'd1;
        if (mo >= ptma_pkg::DECEMBER) begin
          mo_new = ptma_pkg::JANUARY;
          yr_new = yr + 6'd1;
        end else begin
          mo_new = mo + 4'd1;
        end
      end else begin
        dy_new = dnext[4:0];
      end
    end else if (day_step.bwd) begin
      if (dy <= 5'd1) begin
        mo_new = prev_mo;
        yr_new = prev_yr;
        dy_new = ptma_pkg::days_in(prev_yr, prev_mo);
      end else begin
        dy_new = dy - 5'd1;
      end
    end
  end

endmodule

### rtl/packed_timestamp_minute_adder_top.sv
// Top level of the packed timestamp minute adder: input register, datapath, result register.
//
// Adds a signed minute offset to a packed calendar stamp (year offset, month,
// day, hour, minute) and returns the adjusted stamp in the same layout.
// Input channel: in_valid / in_stall with stamp_in and minute_offset; a request
// is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with stamp_out; a result is taken on a
// rising edge with out_valid high and out_stall low.
// A request taken on the input channel goes through the input register, one pass
// of logic and the result register before its result shows on stamp_out.
// Throughput: one request per cycle unless the receiver stalls. The sustained rate
// is set by the single register-to-register pass (divide by 60, hour/minute add, one
// day step). When the receiver stalls, the result register holds; the input register
// still takes one more request if it is empty, then in_stall rises until the result moves.
// Reset (rst, synchronous) empties both stages; no results are pending after it.
module packed_timestamp_minute_adder_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ptma_pkg::STAMP_IN_W-1:0]    stamp_in,
  input  logic [ptma_pkg::OFFSET_W-1:0]      minute_offset,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ptma_pkg::STAMP_OUT_W-1:0]   stamp_out
);

  logic                           s1_valid;
  ptma_pkg::stamp_t               s1_stamp;
  logic [ptma_pkg::OFFSET_W-1:0]  s1_offset;
  logic                           out_load;
  logic                           in_take;

  logic                           neg;
  logic                           nonzero;
  logic [3:0]                     hour_amt;
  logic [ptma_pkg::MIN_W-1:0]     rem;
  logic [ptma_pkg::HOUR_W-1:0]    hr_new;
  logic [ptma_pkg::MIN_W-1:0]     mn_new;
  ptma_pkg::day_step_t            day_step;
  ptma_pkg::stamp_t               res;

  // Pipeline flow control
  assign out_load = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_load;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_stamp  <= ptma_pkg::unpack_stamp(stamp_in);
      s1_offset <= minute_offset;
    end
  end

  // Datapath
  ptma_divmod60 u_divmod60 (
    .offset   (s1_offset),
    .neg      (neg),
    .nonzero  (nonzero),
    .hour_amt (hour_amt),
    .rem      (rem)
  );

  ptma_time_step u_time_step (
    .hr       (s1_stamp.hr),
    .mn       (s1_stamp.mn),
    .neg      (neg),
    .nonzero  (nonzero),
    .hour_amt (hour_amt),
    .rem      (rem),
    .hr_new   (hr_new),
    .mn_new   (mn_new),
    .day_step (day_step)
  );

  ptma_date_step u_date_step (
    .yr       (s1_stamp.yr),
    .mo       (s1_stamp.mo),
    .dy       (s1_stamp.dy),
    .day_step (day_step),
    .yr_new   (res.yr),
    .mo_new   (res.mo),
    .dy_new   (res.dy)
  );

  assign res.hr = hr_new;
  assign res.mn = mn_new;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      stamp_out <= ptma_pkg::pack_stamp(res);
    end
  end

  // Checks
  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled while pipeline can advance");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_load |=> out_valid)
    else $error("request lost between stages");

  a_no_day_both_ways: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(day_step.fwd && day_step.bwd))
    else $error("day carry and borrow at once");

  a_zero_offset_passes: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_load && (s1_offset == '0)
    |=> stamp_out == ptma_pkg::pack_stamp($past(s1_stamp)))
    else $error("zero offset changed the stamp");

endmodule
